[hw/rtl/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the motion smoothness checker
// Widths of the kinematic values, register indexes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package msc_pkg;

    // default position width
    localparam int POS_BITS_DEF = 32;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int GAP_W     = 32;
    localparam int CFG_IDX_W = 3;

    // velocity and acceleration wrap to this width
    localparam int KIN_W  = 48;
    // difference of two kinematic values
    localparam int DVEC_W = KIN_W + 1;
    // sum of three squared differences, and its square root
    localparam int SUM_W  = 98;
    localparam int ROOT_W = SUM_W / 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ACCEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_JERK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_POI  = 3'd4;

    // dividend source of the shared divider
    typedef enum logic [1:0] {
        DIV_POS  = 2'd0,
        DIV_VEL  = 2'd1,
        DIV_NORM = 2'd2
    } div_src_t;

    // vector source of the norm unit
    typedef enum logic {
        NORM_VEL = 1'b0,
        NORM_ACC = 1'b1
    } norm_src_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      div_start;
        div_src_t  div_src;
        logic [1:0] comp;
        logic      vel_write;
        logic      acc_write;
        logic      norm_start;
        norm_src_t norm_src;
        logic      vel_max;
        logic      acc_max;
        logic      jerk_max;
        logic      commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] count;
        logic       div_busy;
        logic       div_done;
        logic       norm_busy;
        logic       norm_done;
    } sts_t;

endpackage

[hw/rtl/msc_div.sv]
// ----------------------------------------------------------------------------
// msc_div: serial unsigned divider
// Restoring division, one quotient bit per cycle. A divisor of one
// skips the shifts and returns the dividend as the quotient.
// ----------------------------------------------------------------------------
module msc_div
    import msc_pkg::*;
#(
    parameter int DIV_W = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [GAP_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] work_reg;
    logic [GAP_W-1:0] rem_reg;
    logic [GAP_W-1:0] dvsr_reg;

    logic [GAP_W:0]   rem_sh;
    logic [GAP_W:0]   rem_sub;
    logic             fits;

    // trial subtract
    always_comb
    begin
        rem_sh  = {rem_reg, work_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, dvsr_reg};
        fits    = (rem_sh >= {1'b0, dvsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            if (divisor == GAP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? rem_sub[GAP_W-1:0] : rem_sh[GAP_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[hw/rtl/msc_norm.sv]
// ----------------------------------------------------------------------------
// msc_norm: Euclidean norm of a 3-vector
// Sum of squares through one 25x25 multiplier over nine partial
// products, then a bit-serial square root, floor result.
// ----------------------------------------------------------------------------
module msc_norm
    import msc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DVEC_W-1:0] vec_x,
    input  logic signed [DVEC_W-1:0] vec_y,
    input  logic signed [DVEC_W-1:0] vec_z,
    output logic                     busy,
    output logic                     done,
    output logic [ROOT_W-1:0]        root
);

    localparam int LO_W  = 25;
    localparam int MUL_W = 2 * LO_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              gen_reg;
    logic              prod_vld_reg;
    logic              sqrt_reg;
    logic              done_reg;
    logic [1:0]        comp_reg;
    logic [1:0]        part_reg;
    logic [1:0]        prod_part_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVEC_W-1:0] mag_reg [3];
    logic [MUL_W-1:0]  prod_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [DVEC_W-1:0] mag_in [3];
    logic [DVEC_W-1:0] cur;
    logic [LO_W-1:0]   op_a;
    logic [LO_W-1:0]   op_b;
    logic [MUL_W-1:0]  product;
    logic [SUM_W-1:0]  addend;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // input magnitudes
    always_comb
    begin
        mag_in[0] = vec_x[DVEC_W-1] ? DVEC_W'(-vec_x) : DVEC_W'(vec_x);
        mag_in[1] = vec_y[DVEC_W-1] ? DVEC_W'(-vec_y) : DVEC_W'(vec_y);
        mag_in[2] = vec_z[DVEC_W-1] ? DVEC_W'(-vec_z) : DVEC_W'(vec_z);
    end

    // partial product select: lo*lo, lo*hi, hi*hi
    always_comb
    begin
        cur = mag_reg[comp_reg];
        case (part_reg)
            2'd0:
            begin
                op_a = cur[LO_W-1:0];
                op_b = cur[LO_W-1:0];
            end
            2'd1:
            begin
                op_a = cur[LO_W-1:0];
                op_b = LO_W'(cur[DVEC_W-1:LO_W]);
            end
            default:
            begin
                op_a = LO_W'(cur[DVEC_W-1:LO_W]);
                op_b = LO_W'(cur[DVEC_W-1:LO_W]);
            end
        endcase
        product = op_a * op_b;
    end

    // place the registered product; the cross term counts twice
    always_comb
    begin
        case (prod_part_reg)
            2'd0:    addend = SUM_W'(prod_reg);
            2'd1:    addend = SUM_W'(prod_reg) << (LO_W + 1);
            default: addend = SUM_W'(prod_reg) << (2 * LO_W);
        endcase
    end

    // one root digit
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], acc_reg[SUM_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= 1'b0;
            prod_vld_reg  <= 1'b0;
            sqrt_reg      <= 1'b0;
            done_reg      <= 1'b0;
            comp_reg      <= '0;
            part_reg      <= '0;
            prod_part_reg <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                gen_reg      <= 1'b1;
                prod_vld_reg <= 1'b0;
                comp_reg     <= '0;
                part_reg     <= '0;
            end
            else
            begin
                if (gen_reg)
                begin
                    prod_vld_reg  <= 1'b1;
                    prod_part_reg <= part_reg;
                    if (part_reg == 2'd2)
                    begin
                        part_reg <= '0;
                        if (comp_reg == 2'd2)
                            gen_reg <= 1'b0;
                        else
                            comp_reg <= comp_reg + 2'd1;
                    end
                    else
                    begin
                        part_reg <= part_reg + 2'd1;
                    end
                end
                else if (prod_vld_reg)
                begin
                    // last product is summed now; root starts next
                    prod_vld_reg <= 1'b0;
                    sqrt_reg     <= 1'b1;
                    cnt_reg      <= CNT_W'(ROOT_W);
                end
                if (sqrt_reg)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        sqrt_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg[0] <= mag_in[0];
            mag_reg[1] <= mag_in[1];
            mag_reg[2] <= mag_in[2];
            acc_reg    <= '0;
        end
        else
        begin
            if (gen_reg)
                prod_reg <= product;
            if (prod_vld_reg)
            begin
                acc_reg  <= acc_reg + addend;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (sqrt_reg)
            begin
                acc_reg  <= {acc_reg[SUM_W-3:0], 2'b00};
                rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
            end
        end
    end

    assign busy = gen_reg | prod_vld_reg | sqrt_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

[hw/rtl/msc_dp.sv]
// ----------------------------------------------------------------------------
// msc_dp: datapath of the motion smoothness checker
// Path state, limits, finite differences, the shared divider and norm
// unit, running maxima and the result register.
// ----------------------------------------------------------------------------
module msc_dp
    import msc_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cmd_t                            cmd,
    output sts_t                            sts,
    input  logic signed [DATA_W-1:0]        frame,
    input  logic signed [POSITION_BITS-1:0] pos_x,
    input  logic signed [POSITION_BITS-1:0] pos_y,
    input  logic signed [POSITION_BITS-1:0] pos_z,
    input  logic [DATA_W-1:0]               target_error,
    input  logic                            tgt_behind,
    input  logic                            poi_enabled,
    input  logic                            last_sample,
    input  logic                            cfg_write,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [DATA_W-1:0]               cfg_data,
    output logic [DATA_W-1:0]               max_target_error,
    output logic [DATA_W-1:0]               max_vel_jump,
    output logic [DATA_W-1:0]               max_accel_jump,
    output logic [DATA_W-1:0]               max_jerk_seen,
    output logic                            fail_target,
    output logic                            fail_velocity,
    output logic                            fail_accel,
    output logic                            fail_jerk,
    output logic                            fail_poi,
    output logic signed [DATA_W-1:0]        first_poi_fail_frame,
    output logic                            path_passed,
    output logic                            path_done
);

    localparam int DIFF_W = (POSITION_BITS < 64) ? POSITION_BITS + 1 : 64;
    localparam int DIV_W  = (DIFF_W > DVEC_W) ? DIFF_W : DVEC_W;

    // limits
    logic [DATA_W-1:0] lim_target_reg;
    logic [DATA_W-1:0] lim_vel_reg;
    logic [DATA_W-1:0] lim_acc_reg;
    logic [DATA_W-1:0] lim_jerk_reg;
    logic              req_poi_reg;

    // current sample
    logic signed [DATA_W-1:0]        frame_reg;
    logic signed [POSITION_BITS-1:0] pos_reg [3];
    logic                            last_reg;
    logic [GAP_W-1:0]                gap_reg;

    // path state
    logic [1:0]                      count_reg;
    logic signed [DATA_W-1:0]        prev_frame_reg;
    logic signed [POSITION_BITS-1:0] prev_pos_reg [3];
    logic signed [KIN_W-1:0]         prev_vel_reg [3];
    logic signed [KIN_W-1:0]         prev_acc_reg [3];
    logic signed [KIN_W-1:0]         vel_reg [3];
    logic signed [KIN_W-1:0]         acc_reg [3];
    logic [DATA_W-1:0]               max_reg [4];
    logic                            poi_failed_reg;
    logic signed [DATA_W-1:0]        poi_frame_reg;
    logic [ROOT_W-1:0]               full_reg;
    logic                            sign_reg;

    // result
    logic [DATA_W-1:0]               out_max_reg [4];
    logic                            out_ft_reg;
    logic                            out_fv_reg;
    logic                            out_fa_reg;
    logic                            out_fj_reg;
    logic                            out_fp_reg;
    logic signed [DATA_W-1:0]        out_pframe_reg;
    logic                            out_done_reg;

    logic signed [DATA_W:0]          fdiff;
    logic [GAP_W-1:0]                gap_in;
    logic [DATA_W-1:0]               terr_in;
    logic signed [DIFF_W-1:0]        pdiff;
    logic [DIFF_W-1:0]               pmag;
    logic signed [DVEC_W-1:0]        vdiff [3];
    logic signed [DVEC_W-1:0]        adiff [3];
    logic [DVEC_W-1:0]               vmag;
    logic [DIV_W-1:0]                dividend;
    logic                            div_sign;
    logic                            div_busy;
    logic                            div_done;
    logic [DIV_W-1:0]                quotient;
    logic [KIN_W-1:0]                q_kin;
    logic signed [KIN_W-1:0]         kin_res;
    logic [DATA_W-1:0]               jerk_sat;
    logic signed [DVEC_W-1:0]        nvec [3];
    logic                            norm_busy;
    logic                            norm_done;
    logic [ROOT_W-1:0]               root;
    logic [DATA_W-1:0]               root_sat;
    logic                            ft;
    logic                            fv;
    logic                            fa;
    logic                            fj;
    logic                            fp;

    // frame gap, not positive counts as one; behind camera is full scale
    always_comb
    begin
        fdiff   = {frame[DATA_W-1], frame} - {prev_frame_reg[DATA_W-1], prev_frame_reg};
        gap_in  = (fdiff[DATA_W] || (fdiff == '0)) ? GAP_W'(1) : fdiff[GAP_W-1:0];
        terr_in = tgt_behind ? '1 : target_error;
    end

    // differences
    always_comb
    begin
        pdiff = DIFF_W'(pos_reg[cmd.comp]) - DIFF_W'(prev_pos_reg[cmd.comp]);
        pmag  = pdiff[DIFF_W-1] ? DIFF_W'(-pdiff) : DIFF_W'(pdiff);
        for (int i = 0; i < 3; i++)
        begin
            vdiff[i] = DVEC_W'(vel_reg[i]) - DVEC_W'(prev_vel_reg[i]);
            adiff[i] = DVEC_W'(acc_reg[i]) - DVEC_W'(prev_acc_reg[i]);
            nvec[i]  = (cmd.norm_src == NORM_ACC) ? adiff[i] : vdiff[i];
        end
        vmag = vdiff[cmd.comp][DVEC_W-1] ? DVEC_W'(-vdiff[cmd.comp])
                                         : DVEC_W'(vdiff[cmd.comp]);
    end

    // divider operand select
    always_comb
    begin
        case (cmd.div_src)
            DIV_POS:
            begin
                dividend = DIV_W'(pmag);
                div_sign = pdiff[DIFF_W-1];
            end
            DIV_VEL:
            begin
                dividend = DIV_W'(vmag);
                div_sign = vdiff[cmd.comp][DVEC_W-1];
            end
            DIV_NORM:
            begin
                dividend = DIV_W'(full_reg);
                div_sign = 1'b0;
            end
            default:
            begin
                dividend = '0;
                div_sign = 1'b0;
            end
        endcase
    end

    msc_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (gap_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    msc_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.norm_start),
        .vec_x (nvec[0]),
        .vec_y (nvec[1]),
        .vec_z (nvec[2]),
        .busy  (norm_busy),
        .done  (norm_done),
        .root  (root)
    );

    // signed, wrapped quotient and saturated values
    always_comb
    begin
        q_kin    = quotient[KIN_W-1:0];
        kin_res  = sign_reg ? KIN_W'(-q_kin) : KIN_W'(q_kin);
        jerk_sat = (|quotient[DIV_W-1:DATA_W]) ? '1 : quotient[DATA_W-1:0];
        root_sat = (|root[ROOT_W-1:DATA_W]) ? '1 : root[DATA_W-1:0];
    end

    // limit checks
    always_comb
    begin
        ft = max_reg[0] > lim_target_reg;
        fv = max_reg[1] > lim_vel_reg;
        fa = max_reg[2] > lim_acc_reg;
        fj = max_reg[3] > lim_jerk_reg;
        fp = req_poi_reg & poi_failed_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_target_reg <= '1;
            lim_vel_reg    <= '1;
            lim_acc_reg    <= '1;
            lim_jerk_reg   <= '1;
            req_poi_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LIMIT_TARGET: lim_target_reg <= cfg_data;
                CFG_LIMIT_VEL:    lim_vel_reg    <= cfg_data;
                CFG_LIMIT_ACCEL:  lim_acc_reg    <= cfg_data;
                CFG_LIMIT_JERK:   lim_jerk_reg   <= cfg_data;
                CFG_REQUIRE_POI:  req_poi_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // path control state: count, maxima, missing point of interest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            max_reg[0]     <= '0;
            max_reg[1]     <= '0;
            max_reg[2]     <= '0;
            max_reg[3]     <= '0;
            poi_failed_reg <= 1'b0;
            poi_frame_reg  <= '0;
        end
        else if (cmd.load)
        begin
            if (terr_in > max_reg[0])
                max_reg[0] <= terr_in;
            if (!poi_enabled && !poi_failed_reg)
            begin
                poi_failed_reg <= 1'b1;
                poi_frame_reg  <= frame;
            end
        end
        else if (cmd.vel_max)
        begin
            if (root_sat > max_reg[1])
                max_reg[1] <= root_sat;
        end
        else if (cmd.acc_max)
        begin
            if (root_sat > max_reg[2])
                max_reg[2] <= root_sat;
        end
        else if (cmd.jerk_max)
        begin
            if (jerk_sat > max_reg[3])
                max_reg[3] <= jerk_sat;
        end
        else if (cmd.commit)
        begin
            if (last_reg)
            begin
                count_reg      <= '0;
                max_reg[0]     <= '0;
                max_reg[1]     <= '0;
                max_reg[2]     <= '0;
                max_reg[3]     <= '0;
                poi_failed_reg <= 1'b0;
                poi_frame_reg  <= '0;
            end
            else if (count_reg != 2'd3)
            begin
                count_reg <= count_reg + 2'd1;
            end
        end
    end

    // sample and history payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_reg  <= frame;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            last_reg   <= last_sample;
            gap_reg    <= gap_in;
        end
        if (cmd.div_start)
            sign_reg <= div_sign;
        if (cmd.vel_write)
            vel_reg[cmd.comp] <= kin_res;
        if (cmd.acc_write)
            acc_reg[cmd.comp] <= kin_res;
        if (cmd.acc_max)
            full_reg <= root;
        if (cmd.commit)
        begin
            prev_frame_reg <= last_reg ? '0 : frame_reg;
            for (int i = 0; i < 3; i++)
            begin
                prev_pos_reg[i] <= pos_reg[i];
                if (count_reg >= 2'd1)
                    prev_vel_reg[i] <= vel_reg[i];
                if (count_reg >= 2'd2)
                    prev_acc_reg[i] <= acc_reg[i];
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < 4; i++)
                out_max_reg[i] <= max_reg[i];
            out_ft_reg     <= ft;
            out_fv_reg     <= fv;
            out_fa_reg     <= fa;
            out_fj_reg     <= fj;
            out_fp_reg     <= fp;
            out_pframe_reg <= fp ? poi_frame_reg : '0;
            out_done_reg   <= last_reg;
        end
    end

    assign sts.count     = count_reg;
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;
    assign sts.norm_busy = norm_busy;
    assign sts.norm_done = norm_done;

    assign max_target_error     = out_max_reg[0];
    assign max_vel_jump         = out_max_reg[1];
    assign max_accel_jump       = out_max_reg[2];
    assign max_jerk_seen        = out_max_reg[3];
    assign fail_target          = out_ft_reg;
    assign fail_velocity        = out_fv_reg;
    assign fail_accel           = out_fa_reg;
    assign fail_jerk            = out_fj_reg;
    assign fail_poi             = out_fp_reg;
    assign first_poi_fail_frame = out_pframe_reg;
    assign path_passed          = ~(out_ft_reg | out_fv_reg | out_fa_reg | out_fj_reg | out_fp_reg);
    assign path_done            = out_done_reg;

endmodule

[hw/rtl/msc_ctrl.sv]
// ----------------------------------------------------------------------------
// msc_ctrl: sequencer of the motion smoothness checker
// Steps one sample, as far as the path history allows, through velocity
// divides, velocity jump norm, acceleration divides, acceleration jump norm and jerk divide.
// ----------------------------------------------------------------------------
module msc_ctrl
    import msc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_VEL_DIV  = 12'b0000_0000_0010,
        S_VEL_WAIT = 12'b0000_0000_0100,
        S_VN_START = 12'b0000_0000_1000,
        S_VN_WAIT  = 12'b0000_0001_0000,
        S_ACC_DIV  = 12'b0000_0010_0000,
        S_ACC_WAIT = 12'b0000_0100_0000,
        S_AN_START = 12'b0000_1000_0000,
        S_AN_WAIT  = 12'b0001_0000_0000,
        S_JRK_DIV  = 12'b0010_0000_0000,
        S_JRK_WAIT = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] comp_reg;
    logic [1:0] comp_next;
    logic       out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        comp_next    = comp_reg;
        cmd          = '0;
        cmd.comp     = comp_reg;
        cmd.div_src  = DIV_POS;
        cmd.norm_src = NORM_VEL;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    comp_next  = '0;
                    state_next = (sts.count == 2'd0) ? S_DONE : S_VEL_DIV;
                end
            end
            S_VEL_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_VEL_WAIT;
            end
            S_VEL_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.vel_write = 1'b1;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = '0;
                        state_next = (sts.count >= 2'd2) ? S_VN_START : S_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_VEL_DIV;
                    end
                end
            end
            S_VN_START:
            begin
                cmd.norm_start = 1'b1;
                state_next     = S_VN_WAIT;
            end
            S_VN_WAIT:
            begin
                if (sts.norm_done)
                begin
                    cmd.vel_max = 1'b1;
                    state_next  = S_ACC_DIV;
                end
            end
            S_ACC_DIV:
            begin
                cmd.div_src   = DIV_VEL;
                cmd.div_start = 1'b1;
                state_next    = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.acc_write = 1'b1;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = '0;
                        state_next = (sts.count == 2'd3) ? S_AN_START : S_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_ACC_DIV;
                    end
                end
            end
            S_AN_START:
            begin
                cmd.norm_src   = NORM_ACC;
                cmd.norm_start = 1'b1;
                state_next     = S_AN_WAIT;
            end
            S_AN_WAIT:
            begin
                if (sts.norm_done)
                begin
                    cmd.acc_max = 1'b1;
                    state_next  = S_JRK_DIV;
                end
            end
            S_JRK_DIV:
            begin
                cmd.div_src   = DIV_NORM;
                cmd.div_start = 1'b1;
                state_next    = S_JRK_WAIT;
            end
            S_JRK_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.jerk_max = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                // write the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    // a result is only written into a free or draining output register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result written over a pending beat");

    // the divider is never restarted while working
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // the norm unit is never restarted while working
    a_norm_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.norm_start |-> !sts.norm_busy)
        else $error("norm unit started while busy");

    // a new result beat always follows a commit
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid without a result");
`endif

endmodule

[hw/rtl/motion_smoothness_checker.sv]
// ----------------------------------------------------------------------------
// motion_smoothness_checker: camera path smoothness checker
// Tracks velocity jump, acceleration jump, jerk and target error maxima
// of a sampled 3-D path and flags them against configured limits.
//
//   channel   direction  handshake            beat
//   in        input      in_valid / in_stall  one path sample
//   out       output     out_valid / out_stall one result with maxima and flags
//   cfg       input      cfg_write            one limit register write
//
// The first sample of a path is only loaded and committed. Later
// samples run, as far as the path history allows, three velocity
// divides, a norm, three acceleration divides, a norm and a jerk divide
// on one serial divider (the shifts are skipped when frames are
// consecutive) and one norm unit (a bit-serial root).
// Reset clears path state and sets the limits to all ones.
// A stalled result is held in the output register while the next
// sample is already accepted and worked on.
// ----------------------------------------------------------------------------
module motion_smoothness_checker
    import msc_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [DATA_W-1:0]        frame,
    input  logic signed [POSITION_BITS-1:0] pos_x,
    input  logic signed [POSITION_BITS-1:0] pos_y,
    input  logic signed [POSITION_BITS-1:0] pos_z,
    input  logic [DATA_W-1:0]               target_error,
    input  logic                            tgt_behind,
    input  logic                            poi_enabled,
    input  logic                            last_sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [DATA_W-1:0]               max_target_error,
    output logic [DATA_W-1:0]               max_vel_jump,
    output logic [DATA_W-1:0]               max_accel_jump,
    output logic [DATA_W-1:0]               max_jerk_seen,
    output logic                            fail_target,
    output logic                            fail_velocity,
    output logic                            fail_accel,
    output logic                            fail_jerk,
    output logic                            fail_poi,
    output logic signed [DATA_W-1:0]        first_poi_fail_frame,
    output logic                            path_passed,
    output logic                            path_done,
    input  logic                            cfg_write,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [DATA_W-1:0]               cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    msc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath
    msc_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .frame                (frame),
        .pos_x                (pos_x),
        .pos_y                (pos_y),
        .pos_z                (pos_z),
        .target_error         (target_error),
        .tgt_behind           (tgt_behind),
        .poi_enabled          (poi_enabled),
        .last_sample          (last_sample),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .max_target_error     (max_target_error),
        .max_vel_jump         (max_vel_jump),
        .max_accel_jump       (max_accel_jump),
        .max_jerk_seen        (max_jerk_seen),
        .fail_target          (fail_target),
        .fail_velocity        (fail_velocity),
        .fail_accel           (fail_accel),
        .fail_jerk            (fail_jerk),
        .fail_poi             (fail_poi),
        .first_poi_fail_frame (first_poi_fail_frame),
        .path_passed          (path_passed),
        .path_done            (path_done)
    );

endmodule
